>>> rtl/mie_pkg.sv
// macro instruction expander package: opcodes, function codes, error codes,
// opcode table, word builder and the expansion record type
// no dependencies
package mie_pkg;

	localparam int MaxWords = 5;

	localparam logic [15:0] OP_LD  = 16'h4000;
	localparam logic [15:0] OP_ST  = 16'h5000;
	localparam logic [15:0] OP_JMP = 16'h6000;
	localparam logic [15:0] OP_JMC = 16'h7000;
	localparam logic [15:0] OP_JAL = 16'h8400;
	localparam logic [15:0] OP_PSH = 16'h8c00;
	localparam logic [15:0] OP_POP = 16'h9200;

	localparam logic [15:0] BASE_NONE = 16'h0000;
	localparam logic [15:0] BASE_B    = 16'h0400;
	localparam logic [15:0] BASE_PC   = 16'h0800;

	localparam logic [7:0] REG_A  = 8'h00;
	localparam logic [7:0] REG_BL = 8'h01;
	localparam logic [7:0] REG_BH = 8'h02;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_NEED_CONST = 3'd1;
	localparam logic [2:0] ERR_NEED_ADDR = 3'd2;
	localparam logic [2:0] ERR_REL_REG   = 3'd3;
	localparam logic [2:0] ERR_BELOW     = 3'd4;
	localparam logic [2:0] ERR_ABOVE     = 3'd5;
	localparam logic [2:0] ERR_NEED_REF  = 3'd6;

	typedef enum logic [3:0] {
		FN_PLAIN = 4'd0,
		FN_LDB   = 4'd1,
		FN_J     = 4'd2,
		FN_JC    = 4'd3,
		FN_SJ    = 4'd4,
		FN_SJC   = 4'd5,
		FN_LLD   = 4'd6,
		FN_LDH   = 4'd7,
		FN_SLD   = 4'd8,
		FN_SST   = 4'd9,
		FN_CALL  = 4'd10,
		FN_PSHB  = 4'd11,
		FN_POPB  = 4'd12,
		FN_PSHM  = 4'd13,
		FN_POPM  = 4'd14,
		FN_RET   = 4'd15
	} func_t;

	typedef struct packed {
		logic [MaxWords-1:0][15:0] words;
		logic [2:0]                n;
		logic                      warn;
		logic [2:0]                err;
	} exp_t;

	function automatic logic [15:0] op_table(input logic [4:0] idx);
		logic [15:0] r;
		unique case (idx)
			5'd0:  r = 16'h4000;
			5'd1:  r = 16'h5000;
			5'd2:  r = 16'h6000;
			5'd3:  r = 16'h7000;
			5'd4:  r = 16'h8400;
			5'd5:  r = 16'h8800;
			5'd6:  r = 16'h8c00;
			5'd7:  r = 16'h9200;
			5'd8:  r = 16'h9400;
			5'd9:  r = 16'ha000;
			5'd10: r = 16'ha400;
			5'd11: r = 16'hac00;
			5'd12: r = 16'hc000;
			5'd13: r = 16'hc400;
			5'd14: r = 16'hc800;
			5'd15: r = 16'hcc00;
			5'd16: r = 16'hd000;
			5'd17: r = 16'hd400;
			5'd18: r = 16'hd800;
			5'd19: r = 16'hdc00;
			5'd20: r = 16'he000;
			5'd21: r = 16'he400;
			5'd22: r = 16'he800;
			5'd23: r = 16'hec00;
			5'd24: r = 16'hf000;
			5'd25: r = 16'hf400;
			5'd26: r = 16'hf800;
			5'd27: r = 16'hfc00;
			default: r = 16'h0000;
		endcase
		return r;
	endfunction

	function automatic logic [15:0] mk_word(input logic ref_b, input logic reg_b,
			input logic [15:0] opc, input logic [15:0] base, input logic [7:0] arg);
		return {6'd0, ref_b, reg_b, 8'd0} | opc | base | {8'd0, arg};
	endfunction

endpackage

>>> rtl/mie_item_if.sv
// input item channel of the macro instruction expander
// depends on nothing
interface mie_item_if;
	logic        valid;
	logic        ready;
	logic [3:0]  func;
	logic [4:0]  op_index;
	logic        is_ref;
	logic        is_reg;
	logic [1:0]  base_sel;
	logic [15:0] operand;
	logic [15:0] item_addr;

	modport source(output valid, func, op_index, is_ref, is_reg, base_sel, operand,
		item_addr, input ready);
	modport sink(input valid, func, op_index, is_ref, is_reg, base_sel, operand,
		item_addr, output ready);
endinterface

>>> rtl/mie_result_if.sv
// result word channel of the macro instruction expander
// depends on nothing
interface mie_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] word;
	logic        last;
	logic        near_warning;
	logic [2:0]  error_code;

	modport source(output valid, word, last, near_warning, error_code, input ready);
	modport sink(input valid, word, last, near_warning, error_code, output ready);
endinterface

>>> rtl/mie_expand.sv
// expansion logic: builds the full word list, count, warning and error of one item
// depends on mie_pkg
module mie_expand
	import mie_pkg::*;
(
	input  logic [3:0]  func,
	input  logic [4:0]  op_index,
	input  logic        is_ref,
	input  logic        is_reg,
	input  logic [1:0]  base_sel,
	input  logic [15:0] operand,
	input  logic [15:0] item_addr,
	output exp_t        exp
);

	logic signed [17:0] disp;
	logic               near;
	logic               below;
	logic               above;
	logic [15:0]        base;
	logic [15:0]        relop;
	func_t              fn;

	assign fn    = func_t'(func);
	assign disp  = $signed({2'b00, operand}) + 18'sd128 - $signed({2'b00, item_addr});
	assign below = disp[17];
	assign above = !disp[17] && (|disp[16:8]);
	assign near  = !below && !above;
	assign base  = {4'd0, base_sel, 10'd0};

	always_comb begin
		exp   = '0;
		relop = OP_JMP;
		unique case (fn) inside
			FN_PLAIN: begin
				exp.words[0] = mk_word(is_ref, is_reg, op_table(op_index), base, operand[7:0]);
				exp.n        = 3'd1;
			end
			FN_LDB, FN_J, FN_JC, FN_CALL, FN_LLD: begin
				exp.words[0] = mk_word(1'b0, 1'b0, OP_LD, BASE_NONE, operand[7:0]);
				exp.words[1] = mk_word(1'b0, 1'b1, OP_ST, BASE_NONE, REG_BL);
				exp.words[2] = mk_word(1'b0, 1'b0, OP_LD, BASE_NONE, operand[15:8]);
				exp.words[3] = mk_word(1'b0, 1'b1, OP_ST, BASE_NONE, REG_BH);
				exp.n        = 3'd5;
				if (fn == FN_LLD) begin
					if (!is_ref || is_reg)
						exp.err = ERR_NEED_ADDR;
				end else if (is_ref || is_reg) begin
					exp.err = ERR_NEED_CONST;
				end
				exp.warn = near && (fn == FN_J || fn == FN_JC || fn == FN_LLD);
				unique case (fn) inside
					FN_J:    exp.words[4] = mk_word(1'b0, 1'b0, OP_JMP, BASE_B, 8'd0);
					FN_JC:   exp.words[4] = mk_word(1'b0, 1'b0, OP_JMC, BASE_B, 8'd0);
					FN_CALL: exp.words[4] = mk_word(1'b0, 1'b0, OP_JAL, BASE_B, 8'd0);
					FN_LLD:  exp.words[4] = mk_word(1'b1, 1'b0, OP_LD, BASE_B, 8'd0);
					default: exp.n        = 3'd4;
				endcase
			end
			FN_SJ, FN_SJC, FN_SLD, FN_SST: begin
				unique case (fn) inside
					FN_SJC:  relop = OP_JMC;
					FN_SLD:  relop = OP_LD;
					FN_SST:  relop = OP_ST;
					default: relop = OP_JMP;
				endcase
				if (is_reg)
					exp.err = ERR_REL_REG;
				else if (below)
					exp.err = ERR_BELOW;
				else if (above)
					exp.err = ERR_ABOVE;
				exp.words[0] = mk_word(is_ref, 1'b0, relop, BASE_PC, disp[7:0]);
				exp.n        = 3'd1;
			end
			FN_LDH: begin
				if ((|base_sel) || is_ref || is_reg)
					exp.err = ERR_NEED_CONST;
				exp.words[0] = mk_word(1'b0, 1'b0, OP_LD, BASE_NONE, operand[15:8]);
				exp.n        = 3'd1;
			end
			FN_PSHB: begin
				exp.words[0] = mk_word(1'b0, 1'b1, OP_PSH, BASE_NONE, REG_BL);
				exp.words[1] = mk_word(1'b0, 1'b1, OP_PSH, BASE_NONE, REG_BH);
				exp.n        = 3'd2;
			end
			FN_POPB, FN_RET: begin
				exp.words[0] = mk_word(1'b0, 1'b0, OP_POP, BASE_NONE, REG_BH);
				exp.words[1] = mk_word(1'b0, 1'b0, OP_POP, BASE_NONE, REG_BL);
				exp.words[2] = mk_word(1'b0, 1'b0, OP_JMP, BASE_B, 8'd0);
				exp.n        = (fn == FN_RET) ? 3'd3 : 3'd2;
			end
			FN_PSHM: begin
				if (!is_ref)
					exp.err = ERR_NEED_REF;
				exp.words[0] = mk_word(is_ref, is_reg, OP_LD, base, operand[7:0]);
				exp.words[1] = mk_word(1'b0, 1'b1, OP_PSH, BASE_NONE, REG_A);
				exp.n        = 3'd2;
			end
			default: begin
				if (!is_ref)
					exp.err = ERR_NEED_REF;
				exp.words[0] = mk_word(1'b0, 1'b1, OP_POP, BASE_NONE, REG_A);
				exp.words[1] = mk_word(is_ref, is_reg, OP_ST, base, operand[7:0]);
				exp.n        = 3'd2;
			end
		endcase
	end

endmodule

>>> rtl/mie_serializer.sv
// result register: holds the expanded words of one item and shifts them out
// one transfer at a time; depends on mie_pkg and mie_result_if
module mie_serializer
	import mie_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              exp_valid,
	input  exp_t              exp,
	output logic              load,
	mie_result_if.source      result
);

	logic [MaxWords-1:0][15:0] words_q;
	logic [2:0]                rem_q;
	logic                      valid_q;
	logic                      warn_q;
	logic [2:0]                err_q;
	logic                      xfer;
	logic                      last;

	assign last = (rem_q == 3'd1);
	assign xfer = valid_q && result.ready;
	assign load = exp_valid && (!valid_q || (xfer && last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rem_q   <= 3'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			rem_q   <= exp.n;
		end else if (xfer) begin
			valid_q <= !last;
			rem_q   <= rem_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			words_q <= exp.words;
			warn_q  <= exp.warn;
			err_q   <= exp.err;
		end else if (xfer) begin
			words_q <= {16'd0, words_q[MaxWords-1:1]};
		end
	end

	assign result.valid        = valid_q;
	assign result.word         = words_q[0];
	assign result.last         = last;
	assign result.near_warning = warn_q;
	assign result.error_code   = err_q;

	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (rem_q != 3'd0 && rem_q <= 3'(MaxWords)))
		else $error("word count out of range while holding an item");

	a_load_count: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (valid_q && rem_q == $past(exp.n)))
		else $error("loaded count differs from expansion");

	a_item_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && !last) |=> (valid_q && warn_q == $past(warn_q) && err_q == $past(err_q)))
		else $error("flags changed inside one item");

	a_no_early_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !xfer) |=> (valid_q && rem_q == $past(rem_q)))
		else $error("item dropped without transfer");

endmodule

>>> rtl/macro_instruction_expander_top.sv
// Macro instruction expander. Each accepted item is caught in an input register,
// expanded combinationally into one to five 16-bit words, and loaded into a result
// register that sends one word per result transfer, the last one marked. An item
// of n words therefore occupies the result channel for n transfers (1 to 5); the
// result register is the rate limit. The first word goes through the input register
// and then the result register, which loads it once free; the next item is taken
// while the current one drains, so single-word items flow at one per cycle while
// the result channel is ready. Warning and error code are the same on every word of
// one item. Depends on mie_pkg, mie_item_if, mie_result_if, mie_expand and mie_serializer.
module macro_instruction_expander_top
	import mie_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	mie_item_if.sink     item,
	mie_result_if.source result
);

	logic        valid_s1;
	logic [3:0]  func_s1;
	logic [4:0]  op_index_s1;
	logic        is_ref_s1;
	logic        is_reg_s1;
	logic [1:0]  base_sel_s1;
	logic [15:0] operand_s1;
	logic [15:0] item_addr_s1;
	logic        load;
	logic        take;
	exp_t        exp;

	assign item.ready = !valid_s1 || load;
	assign take       = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			func_s1      <= item.func;
			op_index_s1  <= item.op_index;
			is_ref_s1    <= item.is_ref;
			is_reg_s1    <= item.is_reg;
			base_sel_s1  <= item.base_sel;
			operand_s1   <= item.operand;
			item_addr_s1 <= item.item_addr;
		end
	end

	mie_expand u_expand (
		.func      (func_s1),
		.op_index  (op_index_s1),
		.is_ref    (is_ref_s1),
		.is_reg    (is_reg_s1),
		.base_sel  (base_sel_s1),
		.operand   (operand_s1),
		.item_addr (item_addr_s1),
		.exp       (exp)
	);

	mie_serializer u_serializer (
		.clk       (clk),
		.arst_n    (arst_n),
		.exp_valid (valid_s1),
		.exp       (exp),
		.load      (load),
		.result    (result)
	);

endmodule
